@@ rtl/core/sros_pkg.sv @@
package sros_pkg;

  localparam int BUFFER_FRAMES = 16384;
  localparam int ADDR_W        = $clog2(BUFFER_FRAMES);
  localparam int CNT_W         = $clog2(BUFFER_FRAMES + 1);
  localparam int SAMPLE_W      = 16;
  localparam int FRAME_W       = 2 * SAMPLE_W;
  localparam int REC_W         = 15;

  typedef enum logic [1:0] {
    ACT_FRAME     = 2'd0,
    ACT_REC_START = 2'd1,
    ACT_REC_STOP  = 2'd2,
    ACT_TRIGGER   = 2'd3
  } action_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    action_t action;
    sample_t in_left;
    sample_t in_right;
  } in_item_t;

  typedef struct packed {
    sample_t          out_left;
    sample_t          out_right;
    logic [REC_W-1:0] recorded_frames;
    logic             active;
  } out_item_t;

  // Q1.15 add with clamp to the 16-bit range.
  function automatic sample_t sat_add(sample_t a, sample_t b);
    logic signed [SAMPLE_W:0] sum;
    sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      sat_add = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat_add = sum[SAMPLE_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/sros_ram.sv @@
module sros_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/stereo_record_and_overdub_sampler.sv @@
// Stereo record / overdub sampler, one stereo Q1.15 frame per beat.
//
// Input channel (in_valid/in_ready/in_data): each beat is an audio frame or a
// command (start record, stop record, trigger playback). Output channel
// (out_valid/out_ready/out_data): exactly one result beat per input beat, in
// order: the input samples plus the playback frame (saturated), the take
// length and the active flag as they stand after that beat.
//
// A beat passes stage 1 and the output register. Throughput is one beat per
// cycle unless the receiver stalls: the control state updates in the accept
// cycle, the frame store is touched once per beat (a write while recording,
// a read while playing) and the read data is summed into the output register.
//
// Reset leaves the block idle in play mode with an empty take; the frame
// store itself is not cleared, since playback only reads entries below the
// take length. When the receiver stalls, the whole two-stage pipe holds and
// in_ready drops, so no beat is lost; the store read port holds its data too.
module stereo_record_and_overdub_sampler
  import sros_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // control state
  logic [CNT_W-1:0] take_len_r, take_len_nxt;
  logic [CNT_W-1:0] play_idx_r, play_idx_nxt;
  logic             play_mode_r, play_mode_nxt;
  logic             idle_r, idle_nxt;

  // stage 1: waiting on store read data
  logic             s1_valid_r;
  sample_t          s1_left_r, s1_right_r;
  logic             s1_play_r;
  logic [REC_W-1:0] s1_rec_r;
  logic             s1_active_r;

  // stage 2: output register
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             advance;
  logic             accept;
  logic             do_write;
  logic             do_read;
  logic [ADDR_W-1:0] ram_addr;
  logic [FRAME_W-1:0] ram_rdata;
  sample_t          add_l, add_r;

  // whole pipe moves together; it stalls only when the result is not taken
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  always_comb begin
    take_len_nxt  = take_len_r;
    play_idx_nxt  = play_idx_r;
    play_mode_nxt = play_mode_r;
    idle_nxt      = idle_r;
    do_write      = 1'b0;
    do_read       = 1'b0;
    ram_addr      = take_len_r[ADDR_W-1:0];
    if (accept) begin
      case (in_data.action)
        ACT_REC_START: begin
          take_len_nxt  = '0;
          play_idx_nxt  = '0;
          play_mode_nxt = 1'b0;
          idle_nxt      = 1'b0;
        end
        ACT_REC_STOP: begin
          play_mode_nxt = 1'b1;
          idle_nxt      = 1'b1;
          play_idx_nxt  = '0;
        end
        ACT_TRIGGER: begin
          idle_nxt     = 1'b0;
          play_idx_nxt = '0;
        end
        ACT_FRAME: begin
          if (!idle_r) begin
            if (play_mode_r) begin
              if (play_idx_r < take_len_r) begin
                do_read      = 1'b1;
                ram_addr     = play_idx_r[ADDR_W-1:0];
                play_idx_nxt = play_idx_r + 1'b1;
                if (play_idx_nxt >= take_len_r) begin
                  idle_nxt = 1'b1;
                end
              end else begin
                // nothing left in the take
                idle_nxt = 1'b1;
              end
            end else if (take_len_r < CNT_W'(BUFFER_FRAMES)) begin
              do_write     = 1'b1;
              take_len_nxt = take_len_r + 1'b1;
            end
            // store full while recording: pass through, stay active
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_len_r  <= '0;
      play_idx_r  <= '0;
      play_mode_r <= 1'b1;
      idle_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      take_len_r  <= take_len_nxt;
      play_idx_r  <= play_idx_nxt;
      play_mode_r <= play_mode_nxt;
      idle_r      <= idle_nxt;
      if (advance) begin
        s1_valid_r  <= accept;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_left_r   <= in_data.in_left;
      s1_right_r  <= in_data.in_right;
      s1_play_r   <= do_read;
      s1_rec_r    <= REC_W'(take_len_nxt);
      s1_active_r <= !idle_nxt;
      out_data_r.out_left        <= sat_add(s1_left_r, add_l);
      out_data_r.out_right       <= sat_add(s1_right_r, add_r);
      out_data_r.recorded_frames <= s1_rec_r;
      out_data_r.active          <= s1_active_r;
    end
  end

  // playback frame: left in the upper half, right in the lower half
  assign add_l = s1_play_r ? sample_t'(ram_rdata[FRAME_W-1:SAMPLE_W]) : '0;
  assign add_r = s1_play_r ? sample_t'(ram_rdata[SAMPLE_W-1:0]) : '0;

  sros_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(BUFFER_FRAMES)
  ) u_frame_store (
    .clk  (clk),
    .en   (do_write || do_read),
    .we   (do_write),
    .addr (ram_addr),
    .wdata({in_data.in_left, in_data.in_right}),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sampler_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, predicts every result at input accept and compares
// each accepted result beat against the oldest prediction.
module sampler_checker
  import sros_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);

  localparam int MAX_PRINTS = 40;

  // Mirror of the sampler state.
  logic [FRAME_W-1:0] take_store [BUFFER_FRAMES];
  int unsigned        take_len;
  int unsigned        play_pos;
  bit                 play_mode;
  bit                 is_idle;

  out_item_t expected_results[$];
  int        fail_tally   = 0;
  int        pending_cnt  = 0;
  int        result_no    = 0;

  assign mismatches  = fail_tally;
  assign outstanding = pending_cnt;

  task automatic report_mismatch(input string msg);
    fail_tally++;
    if (fail_tally <= MAX_PRINTS) begin
      $display("%0t ns: result %0d: %s", $time, result_no, msg);
    end
  endtask

  function automatic sample_t clamp_sum(input sample_t a, input sample_t b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return sample_t'(s);
  endfunction

  // Advance the mirror by one input beat and return the result it causes.
  function automatic out_item_t sampler_step(input in_item_t beat);
    out_item_t res;
    sample_t   add_l;
    sample_t   add_r;
    add_l = '0;
    add_r = '0;
    case (beat.action)
      ACT_REC_START: begin
        take_len  = 0;
        play_pos  = 0;
        play_mode = 1'b0;
        is_idle   = 1'b0;
      end
      ACT_REC_STOP: begin
        play_mode = 1'b1;
        is_idle   = 1'b1;
        play_pos  = 0;
      end
      ACT_TRIGGER: begin
        is_idle  = 1'b0;
        play_pos = 0;
      end
      ACT_FRAME: begin
        if (!is_idle) begin
          if (play_mode) begin
            if (play_pos < take_len) begin
              {add_l, add_r} = take_store[play_pos];
              play_pos++;
              if (play_pos >= take_len) is_idle = 1'b1;
            end else begin
              // empty or exhausted take: pass through, go idle
              is_idle = 1'b1;
            end
          end else if (take_len < BUFFER_FRAMES) begin
            take_store[take_len] = {beat.in_left, beat.in_right};
            take_len++;
          end
        end
      end
    endcase
    res.out_left        = clamp_sum(beat.in_left, add_l);
    res.out_right       = clamp_sum(beat.in_right, add_r);
    res.recorded_frames = REC_W'(take_len);
    res.active          = !is_idle;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      take_len  = 0;
      play_pos  = 0;
      play_mode = 1'b1;
      is_idle   = 1'b1;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no prediction pending");
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_left !== want.out_left)
            report_mismatch($sformatf("out_left got %0d want %0d",
                                      out_data.out_left, want.out_left));
          if (out_data.out_right !== want.out_right)
            report_mismatch($sformatf("out_right got %0d want %0d",
                                      out_data.out_right, want.out_right));
          if (out_data.recorded_frames !== want.recorded_frames)
            report_mismatch($sformatf("recorded_frames got %0d want %0d",
                                      out_data.recorded_frames, want.recorded_frames));
          if (out_data.active !== want.active)
            report_mismatch($sformatf("active got %b want %b",
                                      out_data.active, want.active));
        end
        result_no++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(sampler_step(in_data));
      end
    end
    pending_cnt = expected_results.size();
  end

endmodule

@@ tb/tb_stereo_record_and_overdub_sampler.sv @@
`timescale 1ns / 100ps

// Top of the sampler bench: clock, reset, stimulus, backpressure and the
// verdict. All prediction and comparison lives in sampler_checker.
module tb_stereo_record_and_overdub_sampler;
  import sros_pkg::*;

  localparam int RANDOM_BEATS = 1850;
  localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 12;    // pipe is 2 deep, leave some slack

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int beats_sent = 0;
  int quiet_cycles = 0;

  // When set, both sides run flat out (no gaps, no stalls).
  bit calm = 1'b0;

  stereo_record_and_overdub_sampler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sampler_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample values lean toward the rails and toward zero so saturation and
  // sign boundaries get hit often; the rest is uniform over all 16 bits.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return sample_t'(int'($urandom_range(0, 15)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Present one beat after a random gap and hold it until accepted.
  // Valid is only dropped when a gap follows, so it never toggles twice
  // in one time step.
  task automatic send_beat(input action_t act, input sample_t l, input sample_t r);
    int gap;
    gap = pick_gap();
    if (beats_sent > 0) @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data.action   <= act;
    in_data.in_left  <= l;
    in_data.in_right <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_frame(input sample_t l, input sample_t r);
    send_beat(ACT_FRAME, l, r);
  endtask

  // Commands carry random samples too; they must pass straight through.
  task automatic send_cmd(input action_t act);
    send_beat(act, pick_sample(), pick_sample());
  endtask

  // A well-formed take: record, stop, then one or more playback passes of
  // random length (short, exact, or running past the end of the take).
  task automatic run_take_session();
    int take_n;
    int more;
    calm = ($urandom_range(0, 7) == 0);
    send_cmd(ACT_REC_START);
    take_n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
    repeat (take_n) send_frame(pick_sample(), pick_sample());
    if ($urandom_range(0, 9) == 0) begin
      // trigger while recording: keeps appending to the take
      send_cmd(ACT_TRIGGER);
      more = $urandom_range(1, 6);
      repeat (more) send_frame(pick_sample(), pick_sample());
      take_n += more;
    end
    send_cmd(ACT_REC_STOP);
    repeat ($urandom_range(0, 2)) send_frame(pick_sample(), pick_sample());
    repeat ($urandom_range(1, 3)) begin
      send_cmd(ACT_TRIGGER);
      repeat ($urandom_range(0, take_n + 4)) send_frame(pick_sample(), pick_sample());
    end
  endtask

  // Unstructured beats: any action in any order.
  task automatic send_noise_burst();
    calm = ($urandom_range(0, 7) == 0);
    repeat ($urandom_range(1, 10))
      send_beat(action_t'($urandom_range(0, 3)), pick_sample(), pick_sample());
  endtask

  // Receiver: stall stretches from pick_gap, then a ready burst.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      repeat ($urandom_range(1, 20)) @(negedge clk) out_ready <= 1'b1;
    end
  end

  // Watchdog: any accepted beat on either side counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int rand_base;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // --- directed ---
    // idle after reset: frames pass through at the rails
    send_frame(sample_t'(32767), sample_t'(-32768));
    // trigger on an empty take, then a frame that finds nothing to play
    send_cmd(ACT_TRIGGER);
    send_frame(sample_t'(-32768), sample_t'(32767));
    send_frame(sample_t'(5), sample_t'(-5));
    // record a four-frame take with extreme content
    send_beat(ACT_REC_START, sample_t'(-1), sample_t'(1));
    send_frame(sample_t'(32767), sample_t'(-32768));
    send_frame(sample_t'(-32768), sample_t'(32767));
    send_frame(sample_t'(1), sample_t'(-1));
    send_frame(sample_t'(0), sample_t'(0));
    send_cmd(ACT_REC_STOP);
    send_frame(sample_t'(123), sample_t'(-456));
    // overdub: first two frames clip high and low on both channels
    send_cmd(ACT_TRIGGER);
    send_frame(sample_t'(1), sample_t'(-1));
    send_frame(sample_t'(-1), sample_t'(1));
    send_frame(sample_t'(100), sample_t'(-100));
    send_frame(sample_t'(32767), sample_t'(-32768));  // last stored frame -> idle
    send_frame(sample_t'(7), sample_t'(-7));          // idle again
    // retrigger in the middle of playback
    send_cmd(ACT_TRIGGER);
    send_frame(sample_t'(0), sample_t'(0));
    send_cmd(ACT_TRIGGER);
    send_frame(sample_t'(-2), sample_t'(2));
    // new take, trigger in record mode resumes at the end of the take
    send_cmd(ACT_REC_START);
    send_frame(sample_t'(11), sample_t'(-11));
    send_cmd(ACT_TRIGGER);
    send_frame(sample_t'(-12), sample_t'(12));
    send_cmd(ACT_REC_STOP);

    // --- random ---
    rand_base = beats_sent;
    while (beats_sent - rand_base < RANDOM_BEATS) begin
      if ($urandom_range(0, 99) < 75) run_take_session();
      else send_noise_burst();
    end
    @(negedge clk) in_valid <= 1'b0;

    // drain, then wait out DRAIN_CYCLES so the pipe can show any extra beat
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
